// File: rtl/f12te_pkg.sv
// Shared types, constants and address helpers for the FAT12 table engine.
package f12te_pkg;

  // Default sizes of the table.
  localparam int DEF_MAX_CLUSTER  = 2848;
  localparam int DEF_TABLE_BYTES  = 4608;
  localparam int DEF_SECTOR_BYTES = 512;

  // Field widths.
  localparam int MODE_W  = 3;
  localparam int OFF_W   = 13;
  localparam int BYTE_W  = 8;
  localparam int CLUS_W  = 12;
  localparam int ENTRY_W = 12;
  localparam int FBYTE_W = 21;
  // Bank index width that covers the largest supported table.
  localparam int IDX_W   = 12;

  localparam logic [ENTRY_W-1:0] FREE_ENTRY  = 12'h000;
  localparam logic [BYTE_W-1:0]  LO_NIB_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0]  BYTE_MASK   = 8'hFF;
  localparam logic [FBYTE_W-1:0] FBYTE_MAX   = {FBYTE_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 3'd0,
    MODE_READ  = 3'd1,
    MODE_WRITE = 3'd2,
    MODE_FIND  = 3'd3,
    MODE_COUNT = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_SCAN,
    S_DONE
  } state_t;

  // Byte position of an entry and the word index in each byte bank.
  typedef struct packed {
    logic [OFF_W-1:0] pos;
    logic [IDX_W-1:0] idx_even;
    logic [IDX_W-1:0] idx_odd;
  } ent_map_t;

  // One port request to a byte bank.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } bank_req_t;

  typedef struct packed {
    logic               bad_cluster;
    logic [FBYTE_W-1:0] free_bytes;
    logic [CLUS_W-1:0]  first_free;
    logic               found;
    logic [ENTRY_W-1:0] entry;
  } result_t;

  // Entry n starts at byte floor(3n/2). Even bytes live in one bank, odd bytes
  // in the other, so the two bytes of an entry are always in different banks.
  function automatic ent_map_t ent_map(input logic [CLUS_W-1:0] c);
    ent_map_t         m;
    logic [OFF_W-1:0] p;
    p          = {1'b0, c} + {2'b00, c[CLUS_W-1:1]};
    m.pos      = p;
    m.idx_odd  = p[OFF_W-1:1];
    m.idx_even = p[OFF_W-1:1] + {{(IDX_W-1){1'b0}}, p[0]};
    return m;
  endfunction

endpackage

// File: rtl/f12te_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module f12te_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2304,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/f12te_seq.sv
// Sequencer: decodes each transaction, drives both byte banks and builds the result.
module f12te_seq #(
  parameter int MAX_CLUSTER  = f12te_pkg::DEF_MAX_CLUSTER,
  parameter int TABLE_BYTES  = f12te_pkg::DEF_TABLE_BYTES,
  parameter int SECTOR_BYTES = f12te_pkg::DEF_SECTOR_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [f12te_pkg::MODE_W-1:0]    in_mode,
  input  logic [f12te_pkg::OFF_W-1:0]     in_byte_offset,
  input  logic [f12te_pkg::BYTE_W-1:0]    in_byte_value,
  input  logic [f12te_pkg::CLUS_W-1:0]    in_cluster,
  input  logic [f12te_pkg::ENTRY_W-1:0]   in_entry_value,
  output logic                            res_valid,
  input  logic                            res_ready,
  output f12te_pkg::result_t              res,
  output f12te_pkg::bank_req_t            even_req,
  output f12te_pkg::bank_req_t            odd_req,
  input  logic [f12te_pkg::BYTE_W-1:0]    even_rdata,
  input  logic [f12te_pkg::BYTE_W-1:0]    odd_rdata
);

  import f12te_pkg::*;

  localparam logic [OFF_W:0]     TB_W   = (OFF_W+1)'(TABLE_BYTES);
  localparam logic [CLUS_W-1:0]  MAX_W  = CLUS_W'(MAX_CLUSTER);
  localparam logic [FBYTE_W:0]   SECT_W = (FBYTE_W+1)'(SECTOR_BYTES);
  localparam logic [CLUS_W-1:0]  FIRST_CLUS = 12'd2;

  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt, in_mode_e;
  logic [CLUS_W-1:0]   clus_r, clus_nxt;
  logic [ENTRY_W-1:0]  eval_r, eval_nxt;
  logic [CLUS_W-1:0]   issue_r, issue_nxt;
  logic                chk_valid_r, chk_valid_nxt;
  result_t             res_r, res_nxt;

  logic                accept;
  logic                in_bad;
  ent_map_t            rd_map, dec_map;
  logic                lo_ok, hi_ok;
  logic [BYTE_W-1:0]   lo_byte, hi_byte, new_lo, new_hi;
  logic [ENTRY_W-1:0]  cur_entry;
  logic                hit;
  logic [FBYTE_W:0]    fb_sum;

  assign in_mode_e = mode_t'(in_mode);
  assign accept    = in_valid && in_ready;
  assign in_bad    = in_cluster > MAX_W;

  // The read port follows the incoming cluster while idle and the scan pointer
  // otherwise; data for either comes back in the next cycle against clus_r.
  assign rd_map  = ent_map((state_r == S_IDLE) ? in_cluster : issue_r);
  assign dec_map = ent_map(clus_r);

  // Bytes past the end of the table read as zero and are never written.
  assign lo_ok   = {1'b0, dec_map.pos} < TB_W;
  assign hi_ok   = ({1'b0, dec_map.pos} + (OFF_W+1)'(1)) < TB_W;
  assign lo_byte = lo_ok ? (dec_map.pos[0] ? odd_rdata : even_rdata) : '0;
  assign hi_byte = hi_ok ? (dec_map.pos[0] ? even_rdata : odd_rdata) : '0;

  always_comb begin
    if (clus_r[0]) begin
      cur_entry = {hi_byte, lo_byte[7:4]};
      new_lo    = {eval_r[3:0], lo_byte[3:0] & LO_NIB_MASK[3:0]};
      new_hi    = eval_r[11:4] & BYTE_MASK;
    end else begin
      cur_entry = {hi_byte[3:0] & LO_NIB_MASK[3:0], lo_byte};
      new_lo    = eval_r[7:0] & BYTE_MASK;
      new_hi    = {hi_byte[7:4], eval_r[11:8]};
    end
  end

  assign hit    = chk_valid_r && (cur_entry == FREE_ENTRY);
  assign fb_sum = {1'b0, res_r.free_bytes} + SECT_W;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_mode_e)
            MODE_READ, MODE_WRITE: state_nxt = in_bad ? S_DONE : S_ACCESS;
            MODE_FIND, MODE_COUNT: state_nxt = S_SCAN;
            default:               state_nxt = S_DONE;
          endcase
        end
      end
      S_ACCESS: state_nxt = S_DONE;
      S_SCAN: begin
        if (chk_valid_r) begin
          if ((mode_r == MODE_FIND) && hit) begin
            state_nxt = S_DONE;
          end else if (clus_r == MAX_W) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake and bank port outputs.
  always_comb begin
    in_ready       = (state_r == S_IDLE);
    res_valid      = (state_r == S_DONE);
    res            = res_r;
    even_req.raddr = rd_map.idx_even;
    odd_req.raddr  = rd_map.idx_odd;
    even_req.we    = 1'b0;
    odd_req.we     = 1'b0;
    even_req.waddr = dec_map.idx_even;
    odd_req.waddr  = dec_map.idx_odd;
    even_req.wdata = dec_map.pos[0] ? new_hi : new_lo;
    odd_req.wdata  = dec_map.pos[0] ? new_lo : new_hi;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_mode_e == MODE_LOAD) && ({1'b0, in_byte_offset} < TB_W)) begin
          even_req.waddr = in_byte_offset[OFF_W-1:1];
          odd_req.waddr  = in_byte_offset[OFF_W-1:1];
          even_req.wdata = in_byte_value;
          odd_req.wdata  = in_byte_value;
          even_req.we    = !in_byte_offset[0];
          odd_req.we     = in_byte_offset[0];
        end
      end
      S_ACCESS: begin
        if (mode_r == MODE_WRITE) begin
          even_req.we = dec_map.pos[0] ? hi_ok : lo_ok;
          odd_req.we  = dec_map.pos[0] ? lo_ok : hi_ok;
        end
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_comb begin
    mode_nxt      = mode_r;
    clus_nxt      = clus_r;
    eval_nxt      = eval_r;
    issue_nxt     = issue_r;
    chk_valid_nxt = chk_valid_r;
    res_nxt       = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt      = in_mode_e;
          clus_nxt      = in_cluster;
          eval_nxt      = in_entry_value;
          issue_nxt     = FIRST_CLUS;
          chk_valid_nxt = 1'b0;
          res_nxt       = '0;
          if ((in_mode_e == MODE_READ || in_mode_e == MODE_WRITE) && in_bad) begin
            res_nxt.bad_cluster = 1'b1;
          end
        end
      end
      S_ACCESS: begin
        if (mode_r == MODE_READ) begin
          res_nxt.entry = cur_entry;
        end
      end
      S_SCAN: begin
        if (issue_r <= MAX_W) begin
          clus_nxt      = issue_r;
          issue_nxt     = issue_r + CLUS_W'(1);
          chk_valid_nxt = 1'b1;
        end else begin
          chk_valid_nxt = 1'b0;
        end
        if (hit) begin
          if (mode_r == MODE_FIND) begin
            res_nxt.found      = 1'b1;
            res_nxt.first_free = clus_r;
          end else begin
            // Saturating accumulate gives min(count * sector size, max).
            res_nxt.free_bytes = fb_sum[FBYTE_W] ? FBYTE_MAX : fb_sum[FBYTE_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chk_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_valid_r <= chk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    clus_r  <= clus_nxt;
    eval_r  <= eval_nxt;
    issue_r <= issue_nxt;
    res_r   <= res_nxt;
  end

endmodule

// File: rtl/fat12_table_engine_top.sv
// Top level of the FAT12 table engine: stream ports, output register and byte banks.
//
//   channel  direction  accepted when             contents
//   in_      slave      in_tvalid && in_tready    tuser: mode; tdata: operands
//   out_     master     out_tvalid && out_tready  tdata: one result per item
//
// One transaction is handled at a time. Load byte and the unused modes go
// straight to the result; read entry and write entry first pass an access
// state (read both bytes, then merge), skipped when the cluster is out of range.
// Find and count walk clusters 2..MAX_CLUSTER at one entry per cycle through
// the read ports of the two byte banks: count walks the whole range,
// find stops at the first free entry. Reset clears only control state; table
// bytes hold no value until loaded. A result waits in the output register
// while the next transaction is already taken in.
module fat12_table_engine_top #(
  parameter int MAX_CLUSTER  = f12te_pkg::DEF_MAX_CLUSTER,
  parameter int TABLE_BYTES  = f12te_pkg::DEF_TABLE_BYTES,
  parameter int SECTOR_BYTES = f12te_pkg::DEF_SECTOR_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] mode
  input  logic [2:0]  in_tuser,
  // [12:0] byte_offset, [20:13] byte_value, [32:21] cluster,
  // [44:33] entry_value, [47:45] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [11:0] entry, [12] found, [24:13] first_free, [45:25] free_bytes,
  // [46] bad_cluster, [47] zero
  output logic [47:0] out_tdata
);

  import f12te_pkg::*;

  localparam int EVEN_DEPTH = (TABLE_BYTES + 1) / 2;
  localparam int ODD_DEPTH  = TABLE_BYTES / 2;
  localparam int EVEN_AW    = $clog2(EVEN_DEPTH);
  localparam int ODD_AW     = $clog2(ODD_DEPTH);

  bank_req_t         even_req, odd_req;
  logic [BYTE_W-1:0] even_rdata, odd_rdata;
  result_t           res, res_out_r;
  logic              res_valid, res_ready;
  logic              out_valid_r, out_valid_nxt;

  f12te_seq #(
    .MAX_CLUSTER  (MAX_CLUSTER),
    .TABLE_BYTES  (TABLE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_mode        (in_tuser),
    .in_byte_offset (in_tdata[12:0]),
    .in_byte_value  (in_tdata[20:13]),
    .in_cluster     (in_tdata[32:21]),
    .in_entry_value (in_tdata[44:33]),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res),
    .even_req       (even_req),
    .odd_req        (odd_req),
    .even_rdata     (even_rdata),
    .odd_rdata      (odd_rdata)
  );

  f12te_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (EVEN_DEPTH),
    .AW    (EVEN_AW)
  ) u_even_bank (
    .clk   (clk),
    .we    (even_req.we),
    .waddr (even_req.waddr[EVEN_AW-1:0]),
    .wdata (even_req.wdata),
    .raddr (even_req.raddr[EVEN_AW-1:0]),
    .rdata (even_rdata)
  );

  f12te_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (ODD_DEPTH),
    .AW    (ODD_AW)
  ) u_odd_bank (
    .clk   (clk),
    .we    (odd_req.we),
    .waddr (odd_req.waddr[ODD_AW-1:0]),
    .wdata (odd_req.wdata),
    .raddr (odd_req.raddr[ODD_AW-1:0]),
    .rdata (odd_rdata)
  );

  // The output register frees the sequencer as soon as a result is parked.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_out_r.bad_cluster, res_out_r.free_bytes,
                       res_out_r.first_free, res_out_r.found, res_out_r.entry};

endmodule

// File: rtl/f12te_checker.sv
// Port-level checks for the FAT12 table engine, bound to the top level.
module f12te_checker #(
  parameter int MAX_CLUSTER = f12te_pkg::DEF_MAX_CLUSTER
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  localparam logic [11:0] MAX_W = 12'(MAX_CLUSTER);

  // A result held back by the sink keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Only one transaction is in work at a time, so input is closed after an accept.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // A reported free cluster lies inside the searched range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> (out_tdata[24:13] >= 12'd2) && (out_tdata[24:13] <= MAX_W))
    else $error("free cluster out of range");

  // A rejected cluster carries no other result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[46] |-> (out_tdata[11:0] == 12'd0) && !out_tdata[12] &&
                                    (out_tdata[45:25] == 21'd0))
    else $error("bad cluster result carries data");

  // Reset empties the output register.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind fat12_table_engine_top f12te_checker #(
  .MAX_CLUSTER (MAX_CLUSTER)
) u_f12te_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
